[rtl/dgl_pkg.sv]
`default_nettype none

package dgl_pkg;

   localparam int unsigned CountWidth = 16;
   localparam int unsigned SeqWidth   = 32;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDataWidth = 16;

   typedef enum logic [2:0] {
      CMD_LOCK          = 3'd0,
      CMD_UNLOCK        = 3'd1,
      CMD_RESET_FAULT   = 3'd2,
      CMD_ENABLE_LEFT   = 3'd3,
      CMD_DISABLE_LEFT  = 3'd4,
      CMD_ENABLE_RIGHT  = 3'd5,
      CMD_DISABLE_RIGHT = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      RES_OK          = 2'd0,
      RES_FAULT       = 2'd1,
      RES_NOT_ENABLED = 2'd2,
      RES_NOT_ALIGNED = 2'd3
   } result_type;

   localparam logic REQ_TICK    = 1'b0;
   localparam logic REQ_COMMAND = 1'b1;

   localparam logic [CsrIdxWidth-1:0] CSR_ALIGN_POS_TOL   = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_ALIGN_ROT_TOL   = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_ALIGN_SPEED_TOL = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_STABLE_TICKS    = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_LOST_POS_LIMIT  = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_LOST_ROT_LIMIT  = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CSR_LOST_TICKS      = 3'd6;

   localparam logic [15:0] RST_ALIGN_POS_TOL   = 16'd3000;
   localparam logic [15:0] RST_ALIGN_ROT_TOL   = 16'd350;
   localparam logic [15:0] RST_ALIGN_SPEED_TOL = 16'd200;
   localparam logic [15:0] RST_STABLE_TICKS    = 16'd100;
   localparam logic [15:0] RST_LOST_POS_LIMIT  = 16'd20000;
   localparam logic [15:0] RST_LOST_ROT_LIMIT  = 16'd1500;
   localparam logic [15:0] RST_LOST_TICKS      = 16'd100;

   localparam logic [1:0] SIDES_BOTH = 2'b11;
   localparam logic [1:0] SIDE_LEFT  = 2'b01;
   localparam logic [1:0] SIDE_RIGHT = 2'b10;

   typedef struct packed {
      logic        req_type;
      logic [2:0]  command;
      logic        state_invalid;
      logic [15:0] pos_err_left;
      logic [15:0] pos_err_right;
      logic [15:0] rot_err_left;
      logic [15:0] rot_err_right;
      logic [15:0] lin_speed_left;
      logic [15:0] ang_speed_left;
      logic [15:0] lin_speed_right;
      logic [15:0] ang_speed_right;
   } dgl_req_type;

   typedef struct packed {
      logic        ready_res;
      logic        fault;
      logic [1:0]  locked_mask;
      logic [1:0]  enabled_mask;
      logic [1:0]  last_result;
      logic [31:0] ack_seq;
   } dgl_rsp_type;

   typedef struct packed {
      logic [15:0] align_pos_tol;
      logic [15:0] align_rot_tol;
      logic [15:0] align_speed_tol;
      logic [15:0] stable_ticks;
      logic [15:0] lost_pos_limit;
      logic [15:0] lost_rot_limit;
      logic [15:0] lost_ticks;
   } dgl_cfg_type;

endpackage

`default_nettype wire

[rtl/dgl_cfg.sv]
`default_nettype none

module dgl_cfg
   import dgl_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_wdata,
   output dgl_cfg_type                  cfg
);

   dgl_cfg_type cfg_ff;
   dgl_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ALIGN_POS_TOL:   cfg_in.align_pos_tol   = csr_wdata;
            CSR_ALIGN_ROT_TOL:   cfg_in.align_rot_tol   = csr_wdata;
            CSR_ALIGN_SPEED_TOL: cfg_in.align_speed_tol = csr_wdata;
            CSR_STABLE_TICKS:    cfg_in.stable_ticks    = csr_wdata;
            CSR_LOST_POS_LIMIT:  cfg_in.lost_pos_limit  = csr_wdata;
            CSR_LOST_ROT_LIMIT:  cfg_in.lost_rot_limit  = csr_wdata;
            CSR_LOST_TICKS:      cfg_in.lost_ticks      = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.align_pos_tol   <= RST_ALIGN_POS_TOL;
         cfg_ff.align_rot_tol   <= RST_ALIGN_ROT_TOL;
         cfg_ff.align_speed_tol <= RST_ALIGN_SPEED_TOL;
         cfg_ff.stable_ticks    <= RST_STABLE_TICKS;
         cfg_ff.lost_pos_limit  <= RST_LOST_POS_LIMIT;
         cfg_ff.lost_rot_limit  <= RST_LOST_ROT_LIMIT;
         cfg_ff.lost_ticks      <= RST_LOST_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/dgl_core.sv]
`default_nettype none

module dgl_core
   import dgl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire dgl_req_type item,
   input  wire dgl_cfg_type cfg,
   output dgl_rsp_type      snap
);

   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

   logic [CountWidth-1:0] stable_count_ff, stable_count_in;
   logic [CountWidth-1:0] lost_count_ff, lost_count_in;
   logic                  fault_ff, fault_in;
   logic                  lock_ff, lock_in;
   logic [1:0]            enabled_ff, enabled_in;
   logic                  ready_ff, ready_in;
   result_type            result_ff, result_in;
   logic [SeqWidth-1:0]   seq_ff, seq_in;

   logic        aligned_left;
   logic        aligned_right;
   logic [15:0] speed_left;
   logic [15:0] speed_right;
   logic        sides_on;
   logic        lost;

   assign speed_left  = (item.lin_speed_left > item.ang_speed_left) ?
                        item.lin_speed_left : item.ang_speed_left;
   assign speed_right = (item.lin_speed_right > item.ang_speed_right) ?
                        item.lin_speed_right : item.ang_speed_right;

   assign aligned_left  = (item.pos_err_left < cfg.align_pos_tol) &&
                          (item.rot_err_left < cfg.align_rot_tol) &&
                          (speed_left < cfg.align_speed_tol);
   assign aligned_right = (item.pos_err_right < cfg.align_pos_tol) &&
                          (item.rot_err_right < cfg.align_rot_tol) &&
                          (speed_right < cfg.align_speed_tol);

   assign sides_on = (enabled_ff == SIDES_BOTH);

   assign lost = !sides_on ||
                 (item.pos_err_left > cfg.lost_pos_limit) ||
                 (item.pos_err_right > cfg.lost_pos_limit) ||
                 (item.rot_err_left > cfg.lost_rot_limit) ||
                 (item.rot_err_right > cfg.lost_rot_limit);

   always_comb begin
      stable_count_in = stable_count_ff;
      lost_count_in   = lost_count_ff;
      fault_in        = fault_ff;
      lock_in         = lock_ff;
      enabled_in      = enabled_ff;
      ready_in        = ready_ff;
      result_in       = result_ff;
      seq_in          = seq_ff;
      if (item.req_type == REQ_TICK) begin
         fault_in = fault_ff | item.state_invalid;
         if (aligned_left && aligned_right) begin
            if (stable_count_ff != CountMax) begin
               stable_count_in = stable_count_ff + 1'b1;
            end
         end else begin
            stable_count_in = '0;
         end
         ready_in = !fault_in && sides_on && (stable_count_in >= cfg.stable_ticks);
         if (lock_ff) begin
            if (lost) begin
               if (lost_count_ff != CountMax) begin
                  lost_count_in = lost_count_ff + 1'b1;
               end
            end else begin
               lost_count_in = '0;
            end
            if (lost_count_in > cfg.lost_ticks) begin
               fault_in = 1'b1;
            end
         end else begin
            lost_count_in = '0;
         end
      end else begin
         case (item.command)
            CMD_LOCK: begin
               seq_in = seq_ff + 1'b1;
               if (fault_ff) begin
                  result_in = RES_FAULT;
               end else if (!sides_on) begin
                  result_in = RES_NOT_ENABLED;
               end else if (stable_count_ff < cfg.stable_ticks) begin
                  result_in = RES_NOT_ALIGNED;
               end else begin
                  lock_in   = 1'b1;
                  result_in = RES_OK;
               end
            end
            CMD_UNLOCK: begin
               seq_in    = seq_ff + 1'b1;
               lock_in   = 1'b0;
               result_in = RES_OK;
            end
            CMD_RESET_FAULT: begin
               seq_in = seq_ff + 1'b1;
               if (lock_ff) begin
                  result_in = RES_FAULT;
               end else begin
                  fault_in        = 1'b0;
                  stable_count_in = '0;
                  lost_count_in   = '0;
                  result_in       = RES_OK;
               end
            end
            CMD_ENABLE_LEFT:   enabled_in = enabled_ff | SIDE_LEFT;
            CMD_DISABLE_LEFT:  enabled_in = enabled_ff & SIDE_RIGHT;
            CMD_ENABLE_RIGHT:  enabled_in = enabled_ff | SIDE_RIGHT;
            CMD_DISABLE_RIGHT: enabled_in = enabled_ff & SIDE_LEFT;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_count_ff <= '0;
         lost_count_ff   <= '0;
         fault_ff        <= 1'b0;
         lock_ff         <= 1'b0;
         enabled_ff      <= '0;
         ready_ff        <= 1'b0;
         result_ff       <= RES_OK;
         seq_ff          <= '0;
      end else if (step) begin
         stable_count_ff <= stable_count_in;
         lost_count_ff   <= lost_count_in;
         fault_ff        <= fault_in;
         lock_ff         <= lock_in;
         enabled_ff      <= enabled_in;
         ready_ff        <= ready_in;
         result_ff       <= result_in;
         seq_ff          <= seq_in;
      end
   end

   // result shows the state after this item
   always_comb begin
      snap.ready_res    = ready_in;
      snap.fault        = fault_in;
      snap.locked_mask  = lock_in ? SIDES_BOTH : 2'b00;
      snap.enabled_mask = enabled_in;
      snap.last_result  = result_in;
      snap.ack_seq      = seq_in;
   end

endmodule

`default_nettype wire

[rtl/dual_grasp_lock_interlock.sv]
// Grasp lock safety interlock for a two-sided gripper.
// Input channel req_valid/req_ready/req_data carries one item: a measurement
// tick (alignment and lost-grasp counting, fault latching) or a command
// (lock, unlock, reset fault, enable or disable a side).
// Result channel rsp_valid/rsp_ready/rsp_data returns exactly one item per
// input item: a snapshot of ready, fault, lock and enable masks, last command
// result and the command sequence number after that item.
// Limits and tolerances live in seven 16-bit registers written through
// csr_wr_en/csr_index/csr_wdata; write them only while no item is in flight.
// An accepted item goes through the input register, then the result register,
// which drives rsp_data. Throughput: one item per cycle while the receiver
// does not stall; the state update is a single compare and increment pass
// between the input register and the result register.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; after that req_ready drops until rsp_ready.
// Synchronous reset clears all counters, flags, the sequence number and both
// pipeline stages, and restores the register defaults.
`default_nettype none

module dual_grasp_lock_interlock
   import dgl_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire dgl_req_type             req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output dgl_rsp_type                  rsp_data,
   input  wire logic                    csr_wr_en,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_wdata
);

   dgl_cfg_type cfg;
   dgl_rsp_type snap;

   logic        stage_valid_ff, stage_valid_in;
   dgl_req_type stage_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   dgl_rsp_type rsp_data_ff;
   logic        out_load;
   logic        req_fire;

   assign out_load  = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || out_load;
   assign req_fire  = req_valid && req_ready;

   assign stage_valid_in = req_fire || (stage_valid_ff && !out_load);
   assign rsp_valid_in   = out_load || (rsp_valid_ff && !rsp_ready);

   dgl_cfg u_dgl_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dgl_core u_dgl_core (
      .clock (clock),
      .reset (reset),
      .step  (out_load),
      .item  (stage_data_ff),
      .cfg   (cfg),
      .snap  (snap)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_data_ff <= req_data;
      end
      if (out_load) begin
         rsp_data_ff <= snap;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/dgl_checker.sv]
`default_nettype none

module dgl_checker
   import dgl_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire dgl_rsp_type rsp_data
);

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item valid right after reset");

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   // input side only backs up behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input not ready without a stalled result");

   // both sides always lock together
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.locked_mask == 2'b00 || rsp_data.locked_mask == 2'b11))
      else $error("lock mask shows one side only");

   // a request waiting with free output is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> req_ready)
      else $error("request refused with empty output");

endmodule

bind dual_grasp_lock_interlock dgl_checker u_dgl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
